>>> rtl/ilm_pkg.sv
// Package of shared types, codes and defaults for the idle load monitor.
package ilm_pkg;

    // Default counter width for spin and time arithmetic.
    localparam int COUNT_WIDTH_DEF = 32;

    // Fixed field widths.
    localparam int IN_FIELD_W   = 32;
    localparam int ROUNDS_W     = 8;
    localparam int DELAY_W      = 24;
    localparam int PERCENT_W    = 16;
    localparam int PHASE_CODE_W = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 48;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CAL_ROUNDS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_DELAY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;

    // Configuration reset values.
    localparam logic [ROUNDS_W-1:0] CAL_ROUNDS_RST    = 8'd3;
    localparam logic [DELAY_W-1:0]  MEASURE_DELAY_RST = 24'd100000;
    localparam logic [DELAY_W-1:0]  SAMPLE_PERIOD_RST = 24'd1000000;

    // Delay requested after a calibration round that is not the last one.
    localparam logic [DELAY_W-1:0]  REALIGN_DELAY = 24'd1;

    // Phase codes as reported in the result item.
    localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_ALIGN   = 2'd0;
    localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_MEASURE = 2'd1;
    localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_SAMPLE  = 2'd2;

    // Requests from the top level to the serial arithmetic unit.
    typedef struct packed {
        logic start;
        logic take;
    } arith_req_t;

    // Status from the serial arithmetic unit.
    typedef struct packed {
        logic                 valid;
        logic [PERCENT_W-1:0] percent;
    } arith_stat_t;

endpackage

>>> rtl/ilm_serial_arith.sv
// Bit-serial multiply, divide, scale and divide unit for the idle percentage.
module ilm_serial_arith #(
    parameter int W = ilm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ilm_pkg::arith_req_t req,
    input  logic [W-1:0]        op_a,   // sample spins
    input  logic [W-1:0]        op_b,   // calibration interval
    input  logic [W-1:0]        op_c,   // sample interval
    input  logic [W-1:0]        op_d,   // calibration spins
    output ilm_pkg::arith_stat_t stat
);

    localparam int CW = $clog2(W);

    typedef enum logic [5:0] {
        A_IDLE  = 6'b000001,
        A_MUL   = 6'b000010,
        A_DIV1  = 6'b000100,
        A_SCALE = 6'b001000,
        A_DIV2  = 6'b010000,
        A_DONE  = 6'b100000
    } arith_state_t;

    arith_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  mcand_reg, mcand_next;
    logic [W-1:0]  mplier_reg, mplier_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;

    logic [W-1:0]  acc_sum;
    logic [W-1:0]  divisor;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          qbit;
    logic [W-1:0]  rem_step;

    assign acc_sum  = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
    assign divisor  = (state_reg == A_DIV2) ? op_d : op_c;
    assign shifted  = {rem_reg, quo_reg[W-1]};
    assign diff     = shifted - {1'b0, divisor};
    assign qbit     = ~diff[W];
    assign rem_step = qbit ? diff[W-1:0] : shifted[W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    acc_next    = '0;
                    mcand_next  = op_a;
                    mplier_next = op_b;
                    cnt_next    = CW'(W - 1);
                    if ((op_c == '0) || (op_d == '0))
                    begin
                        quo_next   = '0;
                        state_next = A_DONE;
                    end
                    else
                    begin
                        state_next = A_MUL;
                    end
                end
            end
            A_MUL:
            begin
                acc_next    = acc_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (cnt_reg == '0)
                begin
                    quo_next   = acc_sum;
                    rem_next   = '0;
                    cnt_next   = CW'(W - 1);
                    state_next = A_DIV1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            A_DIV1, A_DIV2:
            begin
                rem_next = rem_step;
                quo_next = {quo_reg[W-2:0], qbit};
                if (cnt_reg == '0)
                begin
                    state_next = (state_reg == A_DIV1) ? A_SCALE : A_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            A_SCALE:
            begin
                // Times 100 as 64 + 32 + 4, wrapping to W bits.
                quo_next   = (quo_reg << 6) + (quo_reg << 5) + (quo_reg << 2);
                rem_next   = '0;
                cnt_next   = CW'(W - 1);
                state_next = A_DIV2;
            end
            A_DONE:
            begin
                if (req.take)
                begin
                    state_next = A_IDLE;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

    assign stat.valid   = (state_reg == A_DONE);
    assign stat.percent = quo_reg[ilm_pkg::PERCENT_W-1:0];

endmodule

>>> rtl/idle_load_monitor_core.sv
// Top level of the idle load monitor: phase sequencing, state and result staging.
//
// Usage: every item on the slave stream is one timed activation; s_tdata holds
// spin_count in bits 31:0 and time_us in bits 63:32. Every accepted item gives
// exactly one result item on the master stream. The block first runs the
// configured number of align and measure rounds, keeping the spin and time
// deltas of the last measure, then takes periodic samples. Each result carries
// the next delay to schedule, a calibration-done pulse, the idle percentage
// and the phase after the step.
// The idle percentage comes from a bit-serial unit: a start step, a shift-add
// multiply, a restoring divide, one scaling step and a second divide, all at
// COUNT_WIDTH bits. With either divisor zero the unit is skipped and the
// percentage is zero. The next item is taken only after the result of the
// last one has moved to the output register.
// s_tready is low while an item is in work. The next item may be accepted
// while a finished result still waits in the output register; if the receiver
// stalls, the following result waits in the serial unit until the register
// frees. Configuration writes take effect at once. Reset returns the phase to
// align, clears all stored deltas and round counts and loads the defaults.
module idle_load_monitor_core #(
    parameter int COUNT_WIDTH = ilm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [ilm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ilm_pkg::DELAY_W-1:0]      cfg_wdata,
    // Activation stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: spin_count[31:0], time_us[63:32].
    input  logic [ilm_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0: next_delay_us[23:0], calibration_done[24],
    // idle_percent[40:25], phase_now[42:41], zero fill[47:43].
    output logic [ilm_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int W = COUNT_WIDTH;

    // One-hot phase register; mapped to the reported codes at the output.
    typedef enum logic [2:0] {
        PH_ALIGN   = 3'b001,
        PH_MEASURE = 3'b010,
        PH_SAMPLE  = 3'b100
    } phase_t;

    // Configuration registers.
    logic [ilm_pkg::ROUNDS_W-1:0] cal_rounds_reg;
    logic [ilm_pkg::DELAY_W-1:0]  measure_delay_reg;
    logic [ilm_pkg::DELAY_W-1:0]  sample_period_reg;

    // Monitor state.
    phase_t                       phase_reg, phase_next;
    logic [ilm_pkg::ROUNDS_W-1:0] rounds_done_reg, rounds_done_next;
    logic [W-1:0]                 prev_spins_reg;
    logic [W-1:0]                 prev_time_reg;
    logic [W-1:0]                 calib_spins_reg, calib_spins_next;
    logic [W-1:0]                 calib_interval_reg, calib_interval_next;
    logic [W-1:0]                 sample_spins_reg, sample_spins_next;
    logic [W-1:0]                 sample_interval_reg, sample_interval_next;

    // Item control and staged result fields.
    logic                         busy_reg;
    logic                         start_reg;
    logic [ilm_pkg::DELAY_W-1:0]  pend_delay_reg, delay_next;
    logic                         pend_done_reg, done_next;
    logic [ilm_pkg::PHASE_CODE_W-1:0] pend_phase_reg, phase_code_next;
    logic                         m_tvalid_reg;
    logic [ilm_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic                         in_accept;
    logic                         out_load;
    logic [W-1:0]                 spins_w;
    logic [W-1:0]                 now_w;
    logic [ilm_pkg::ROUNDS_W:0]   rounds_inc;

    ilm_pkg::arith_req_t          arith_req;
    ilm_pkg::arith_stat_t         arith_stat;

    assign s_tready  = ~busy_reg;
    assign in_accept = s_tvalid & s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Counter fields are taken at the configured counter width.
    assign spins_w = COUNT_WIDTH'(s_tdata[ilm_pkg::IN_FIELD_W-1:0]);
    assign now_w   = COUNT_WIDTH'(s_tdata[2*ilm_pkg::IN_FIELD_W-1:ilm_pkg::IN_FIELD_W]);

    assign rounds_inc = {1'b0, rounds_done_reg} + 1'b1;

    // A finished percentage moves to the output register once it is free.
    assign out_load = busy_reg & arith_stat.valid & (~m_tvalid_reg | m_tready);

    assign arith_req.start = start_reg;
    assign arith_req.take  = out_load;

    // Phase step for one activation.
    always_comb
    begin
        phase_next           = phase_reg;
        rounds_done_next     = rounds_done_reg;
        calib_spins_next     = calib_spins_reg;
        calib_interval_next  = calib_interval_reg;
        sample_spins_next    = sample_spins_reg;
        sample_interval_next = sample_interval_reg;
        delay_next           = measure_delay_reg;
        done_next            = 1'b0;
        case (phase_reg)
            PH_MEASURE:
            begin
                calib_spins_next    = spins_w - prev_spins_reg;
                calib_interval_next = now_w - prev_time_reg;
                // The round count saturates at its top value.
                rounds_done_next    = rounds_inc[ilm_pkg::ROUNDS_W]
                                    ? rounds_done_reg
                                    : rounds_inc[ilm_pkg::ROUNDS_W-1:0];
                // A zero round setting ends calibration at the first measure.
                if (rounds_inc >= {1'b0, cal_rounds_reg})
                begin
                    phase_next = PH_SAMPLE;
                    delay_next = sample_period_reg;
                    done_next  = 1'b1;
                end
                else
                begin
                    phase_next = PH_ALIGN;
                    delay_next = ilm_pkg::REALIGN_DELAY;
                end
            end
            PH_SAMPLE:
            begin
                sample_spins_next    = spins_w - prev_spins_reg;
                sample_interval_next = now_w - prev_time_reg;
                delay_next           = sample_period_reg;
            end
            default:
            begin
                phase_next = PH_MEASURE;
                delay_next = measure_delay_reg;
            end
        endcase
    end

    always_comb
    begin
        case (phase_next)
            PH_MEASURE: phase_code_next = ilm_pkg::PHASE_CODE_MEASURE;
            PH_SAMPLE:  phase_code_next = ilm_pkg::PHASE_CODE_SAMPLE;
            default:    phase_code_next = ilm_pkg::PHASE_CODE_ALIGN;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_rounds_reg    <= ilm_pkg::CAL_ROUNDS_RST;
            measure_delay_reg <= ilm_pkg::MEASURE_DELAY_RST;
            sample_period_reg <= ilm_pkg::SAMPLE_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ilm_pkg::REG_CAL_ROUNDS:
                    cal_rounds_reg <= cfg_wdata[ilm_pkg::ROUNDS_W-1:0];
                ilm_pkg::REG_MEASURE_DELAY:
                    measure_delay_reg <= cfg_wdata;
                ilm_pkg::REG_SAMPLE_PERIOD:
                    sample_period_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Monitor state is updated when an activation is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_ALIGN;
            rounds_done_reg     <= '0;
            prev_spins_reg      <= '0;
            prev_time_reg       <= '0;
            calib_spins_reg     <= '0;
            calib_interval_reg  <= '0;
            sample_spins_reg    <= '0;
            sample_interval_reg <= '0;
        end
        else if (in_accept)
        begin
            phase_reg           <= phase_next;
            rounds_done_reg     <= rounds_done_next;
            prev_spins_reg      <= spins_w;
            prev_time_reg       <= now_w;
            calib_spins_reg     <= calib_spins_next;
            calib_interval_reg  <= calib_interval_next;
            sample_spins_reg    <= sample_spins_next;
            sample_interval_reg <= sample_interval_next;
        end
    end

    // Item control: the serial unit starts the cycle after acceptance, once
    // the stored deltas hold this activation's values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= in_accept;
            if (in_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_load)
            begin
                busy_reg <= 1'b0;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload staging.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pend_delay_reg <= delay_next;
            pend_done_reg  <= done_next;
            pend_phase_reg <= phase_code_next;
        end
        if (out_load)
        begin
            m_tdata_reg <= {5'b0, pend_phase_reg, arith_stat.percent,
                            pend_done_reg, pend_delay_reg};
        end
    end

    ilm_serial_arith #(
        .W (COUNT_WIDTH)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .op_a  (sample_spins_reg),
        .op_b  (calib_interval_reg),
        .op_c  (sample_interval_reg),
        .op_d  (calib_spins_reg),
        .stat  (arith_stat)
    );

    // An accepted item keeps the block busy until its result is staged.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> busy_reg)
        else $error("block not busy after an accepted item");

    // The serial unit never holds a result without an item in work.
    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        arith_stat.valid |-> busy_reg)
        else $error("serial result without a pending item");

    // The calibration pulse only comes with the move to periodic sampling.
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[24]) |->
            (m_tdata_reg[42:41] == ilm_pkg::PHASE_CODE_SAMPLE))
        else $error("calibration done outside the sample phase");

endmodule

>>> test/idle_load_checker.sv
// Checker for the idle load monitor: predicts each result item and compares it with the block.
`timescale 1ns / 1ps

module idle_load_checker
    import ilm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DELAY_W-1:0]     cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // Fields from bit 0: spin_count[31:0], time_us[63:32].
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: next_delay_us[23:0], calibration_done[24],
    // idle_percent[40:25], phase_now[42:41], zero fill[47:43].
    input  logic [M_TDATA_W-1:0]   m_tdata,
    output int                     error_count,
    output int                     pending,
    output int                     results_checked,
    output int                     done_pulses
);

    localparam int CW           = COUNT_WIDTH_DEF;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DELAY_W-1:0]      next_delay;
        logic                    cal_done;
        logic [PERCENT_W-1:0]    idle_pct;
        logic [PHASE_CODE_W-1:0] phase_after;
    } monitor_report_t;

    // Register copies.
    logic [ROUNDS_W-1:0] rounds_cfg;
    logic [DELAY_W-1:0]  measure_delay_cfg;
    logic [DELAY_W-1:0]  sample_period_cfg;

    // Monitor state.
    logic [PHASE_CODE_W-1:0] phase_q;
    logic [ROUNDS_W-1:0]     rounds_done_q;
    logic [CW-1:0]           prev_spins_q;
    logic [CW-1:0]           prev_clock_q;
    logic [CW-1:0]           calib_spins_q;
    logic [CW-1:0]           calib_interval_q;
    logic [CW-1:0]           sample_spins_q;
    logic [CW-1:0]           sample_interval_q;

    monitor_report_t awaited_reports[$];
    monitor_report_t fresh_report;
    monitor_report_t want;
    int              mismatches;
    int              shown;
    int              checked;
    int              pulses;

    // Wrapping integer arithmetic at the counter width; zero when a divisor is zero.
    function automatic logic [PERCENT_W-1:0] idle_share();
        logic [CW-1:0] x;
        if (sample_interval_q == '0 || calib_spins_q == '0)
            return '0;
        x = sample_spins_q * calib_interval_q;
        x = x / sample_interval_q;
        x = x * CW'(100);
        x = x / calib_spins_q;
        return x[PERCENT_W-1:0];
    endfunction

    task automatic account_activation(input logic [CW-1:0] spins, input logic [CW-1:0] now,
                                      output monitor_report_t res);
        logic [ROUNDS_W:0] next_round;
        res.cal_done = 1'b0;
        case (phase_q)
            PHASE_CODE_MEASURE:
            begin
                next_round       = {1'b0, rounds_done_q} + 1'b1;
                calib_spins_q    = spins - prev_spins_q;
                calib_interval_q = now - prev_clock_q;
                rounds_done_q    = next_round[ROUNDS_W] ? '1 : next_round[ROUNDS_W-1:0];
                // A rounds setting of zero behaves like one.
                if (next_round >= {1'b0, rounds_cfg})
                begin
                    phase_q        = PHASE_CODE_SAMPLE;
                    res.next_delay = sample_period_cfg;
                    res.cal_done   = 1'b1;
                end
                else
                begin
                    phase_q        = PHASE_CODE_ALIGN;
                    res.next_delay = REALIGN_DELAY;
                end
            end
            PHASE_CODE_SAMPLE:
            begin
                sample_spins_q    = spins - prev_spins_q;
                sample_interval_q = now - prev_clock_q;
                res.next_delay    = sample_period_cfg;
            end
            default:
            begin
                phase_q        = PHASE_CODE_MEASURE;
                res.next_delay = measure_delay_cfg;
            end
        endcase
        prev_spins_q    = spins;
        prev_clock_q    = now;
        res.idle_pct    = idle_share();
        res.phase_after = phase_q;
    endtask

    task automatic check_field(input string label, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatches++;
            if (shown < REPORT_LIMIT)
            begin
                shown++;
                $display("%t: %s mismatch, expected %0h, got %0h", $realtime, label,
                         exp_val, act_val);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounds_cfg        = CAL_ROUNDS_RST;
            measure_delay_cfg = MEASURE_DELAY_RST;
            sample_period_cfg = SAMPLE_PERIOD_RST;
            phase_q           = PHASE_CODE_ALIGN;
            rounds_done_q     = '0;
            prev_spins_q      = '0;
            prev_clock_q      = '0;
            calib_spins_q     = '0;
            calib_interval_q  = '0;
            sample_spins_q    = '0;
            sample_interval_q = '0;
            awaited_reports.delete();
            mismatches        = 0;
            shown             = 0;
            checked           = 0;
            pulses            = 0;
            error_count      <= 0;
            pending          <= 0;
            results_checked  <= 0;
            done_pulses      <= 0;
        end
        else
        begin
            // Results are matched before this edge's item is added, so a result
            // can never be matched against its own activation.
            if (m_tvalid && m_tready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    mismatches++;
                    if (shown < REPORT_LIMIT)
                    begin
                        shown++;
                        $display("%t: result item %h with no activation outstanding",
                                 $realtime, m_tdata);
                    end
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("next_delay_us", 32'(want.next_delay), 32'(m_tdata[23:0]));
                    check_field("calibration_done", 32'(want.cal_done), 32'(m_tdata[24]));
                    check_field("idle_percent", 32'(want.idle_pct), 32'(m_tdata[40:25]));
                    check_field("phase_now", 32'(want.phase_after), 32'(m_tdata[42:41]));
                    check_field("zero fill", 32'd0, 32'(m_tdata[47:43]));
                    checked++;
                    if (m_tdata[24])
                        pulses++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CAL_ROUNDS:    rounds_cfg        = cfg_wdata[ROUNDS_W-1:0];
                    REG_MEASURE_DELAY: measure_delay_cfg = cfg_wdata;
                    REG_SAMPLE_PERIOD: sample_period_cfg = cfg_wdata;
                    default:           ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                account_activation(s_tdata[31:0], s_tdata[63:32], fresh_report);
                awaited_reports.push_back(fresh_report);
            end
            error_count     <= mismatches;
            pending         <= awaited_reports.size();
            results_checked <= checked;
            done_pulses     <= pulses;
        end
    end

endmodule

>>> test/testbench.sv
// Top of the idle load monitor testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module testbench;
    import ilm_pkg::*;

    // Watchdog bound on the whole run, with ample margin.
    localparam int CYCLE_LIMIT     = 2_500_000;
    // Receiver hold-off long enough to back the block up into its input.
    localparam int HOLD_OFF_CYCLES = 3000;
    // Covers one full serial computation plus some slack.
    localparam int DRAIN_CYCLES    = 120;
    // The register index that maps to nothing; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [DELAY_W-1:0]     DELAY_MAX  = 24'hFF_FFFF;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DELAY_W-1:0]     cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    // Fields from bit 0: spin_count[31:0], time_us[63:32].
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // Fields from bit 0: next_delay_us[23:0], calibration_done[24],
    // idle_percent[40:25], phase_now[42:41], zero fill[47:43].
    logic [M_TDATA_W-1:0]   m_tdata;

    int error_count;
    int pending;
    int results_checked;
    int done_pulses;

    // Stimulus bookkeeping. spin_now and clock_now hold the last values sent, so
    // that well-formed activations can advance both counters by chosen deltas.
    logic [31:0] spin_now;
    logic [31:0] clock_now;
    int          cal_items;
    int          sample_items;
    int          cfg_writes;
    int          cycle_count;

    // Shared control between the stimulus and the receiver. no_idle switches off
    // every gap on both sides; hold_off_req asks the receiver for one long stall.
    bit no_idle;
    bit hold_off_req;

    idle_load_monitor_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    idle_load_checker monitor_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .error_count     (error_count),
        .pending         (pending),
        .results_checked (results_checked),
        .done_pulses     (done_pulses)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Length of an idle stretch, drawn mostly from the shortest of three ranges and
    // rarely from the longest, so that gaps land on every stage of the serial computation.
    function automatic int idle_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 40);
        else
            return $urandom_range(60, 250);
    endfunction

    // Result receiver. Every assignment to m_tready is followed by a clock edge
    // before the next one, so the signal never sees two updates in one time step.
    initial
    begin
        int  span;
        bit  ready_now;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if (no_idle)
                begin
                    ready_now = 1'b1;
                    span      = 1;
                end
                else
                begin
                    ready_now = ($urandom_range(0, 99) < 70);
                    if (!ready_now)
                        span = idle_span();
                    else if ($urandom_range(0, 9) == 0)
                        span = $urandom_range(100, 400);
                    else
                        span = $urandom_range(1, 8);
                end
                m_tready <= ready_now;
                repeat (span) @(posedge clk);
            end
        end
    end

    // Offers one activation and holds it until the block takes it. The valid
    // stays high into the next item when no gap follows.
    task automatic send_activation(input logic [31:0] spins, input logic [31:0] stamp);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, spins};
        do
            @(posedge clk);
        while (!s_tready);
        spin_now  = spins;
        clock_now = stamp;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_span();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Advances the spin counter and the microsecond clock by the given deltas.
    task automatic send_step(input logic [31:0] spin_delta, input logic [31:0] clock_delta);
        send_activation(spin_now + spin_delta, clock_now + clock_delta);
    endtask

    // Mostly plausible activations (clock moves forward, spins at up to a given
    // rate), with some fully random words and some zero-interval or zero-spin
    // steps mixed in.
    task automatic send_random(input int max_interval, input int spins_per_us);
        int roll;
        int dt;
        roll = $urandom_range(0, 99);
        dt   = $urandom_range(1, max_interval);
        if (roll < 8)
            send_activation($urandom, $urandom);
        else if (roll < 12)
            send_step($urandom_range(0, 3), 32'd0);
        else if (roll < 15)
            send_step(32'd0, dt);
        else
            send_step($urandom_range(0, dt * spins_per_us), dt);
    endtask

    // Waits until every activation sent so far has produced its result. A clock
    // edge passes first so the checker has registered the last acceptance.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges, optionally followed by a
    // write to the unmapped index, which must leave the settings unchanged.
    task automatic configure(input logic [DELAY_W-1:0] rounds_word,
                             input logic [DELAY_W-1:0] measure_word,
                             input logic [DELAY_W-1:0] period_word,
                             input bit poke_unused);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CAL_ROUNDS;
        cfg_wdata <= rounds_word;
        @(posedge clk);
        cfg_index <= REG_MEASURE_DELAY;
        cfg_wdata <= measure_word;
        @(posedge clk);
        cfg_index <= REG_SAMPLE_PERIOD;
        cfg_wdata <= period_word;
        @(posedge clk);
        cfg_writes += 3;
        if (poke_unused)
        begin
            cfg_index <= REG_UNUSED;
            cfg_wdata <= DELAY_W'($urandom);
            @(posedge clk);
            cfg_writes++;
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int                 k;
        logic [DELAY_W-1:0] rounds_word;
        logic [DELAY_W-1:0] measure_word;
        logic [DELAY_W-1:0] period_word;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_CAL_ROUNDS;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        spin_now     = '0;
        clock_now    = '0;
        cal_items    = 0;
        sample_items = 0;
        cfg_writes   = 0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two calibration rounds under the reset settings with extreme counter
        // values: all ones, wrapping deltas, and a measure that sees no spins
        // and no time at all.
        send_activation(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_activation(32'h0000_0004, 32'h0001_869F);
        send_activation(32'h0000_0000, 32'h0000_0000);
        send_activation(32'h0000_0000, 32'h0000_0000);
        cal_items += 4;
        wait_results_drained();

        // Long calibration with random content. The rounds setting jumps while
        // rounds are already counted, but always stays above the count, so the
        // block keeps alternating between align and measure. The measure delay
        // goes through zero, one and its maximum.
        for (k = 0; k < 5; k++)
        begin
            case (k)
                0:       begin rounds_word = 24'd255; measure_word = 24'd0;     end
                1:       begin rounds_word = 24'd200; measure_word = 24'd1;     end
                2:       begin rounds_word = 24'd255; measure_word = DELAY_MAX; end
                3:       begin rounds_word = 24'd180; measure_word = DELAY_W'($urandom); end
                default: begin rounds_word = 24'd255; measure_word = DELAY_W'($urandom); end
            endcase
            configure(rounds_word, measure_word, DELAY_W'($urandom), 1'b0);
            repeat (20)
            begin
                send_random(200000, 4);
                send_random(200000, 4);
            end
            cal_items += 40;
            wait_results_drained();
        end

        // A rounds setting of zero acts like one, so the next measure closes
        // calibration with the done pulse. The interval and spin count of that
        // measure are kept small and nonzero so that later percentages carry
        // real values.
        configure(24'd0, 24'd1, DELAY_MAX, 1'b0);
        send_step($urandom_range(0, 5000), 32'd1);
        send_step($urandom_range(3000, 9000), $urandom_range(800, 1500));
        cal_items += 2;

        // Directed periodic samples: zero interval, zero spins, an overflowing
        // spin delta, an ordinary one, then both counters at all ones and back
        // to zero.
        send_step(32'd1000, 32'd0);
        send_step(32'd0, 32'd5000);
        send_step(32'hFFFF_FFFF, 32'd1);
        send_step(32'd6000, 32'd10000);
        send_activation(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_activation(32'h0000_0000, 32'h0000_0000);
        sample_items += 6;
        wait_results_drained();

        // Periodic sampling in chunks. Each chunk starts from an idle block with
        // new settings: the sample period runs through zero, one, its maximum
        // and random values, and the rounds register gets random words with
        // upper write bits set. One chunk holds the receiver off long enough to
        // stall the input, and one runs without gaps on either side.
        for (k = 0; k < 8; k++)
        begin
            case (k)
                0:       period_word = 24'd0;
                1:       period_word = 24'd1;
                2:       period_word = DELAY_MAX;
                default: period_word = DELAY_W'($urandom);
            endcase
            configure(DELAY_W'($urandom), DELAY_W'($urandom), period_word, k == 0);
            if (k == 3)
                hold_off_req = 1'b1;
            no_idle = (k == 5);
            repeat (100)
                send_random(20000, 6);
            sample_items += 100;
            wait_results_drained();
            no_idle = 1'b0;
        end

        // Give a late or stray result time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d activations: %0d during calibration, %0d periodic samples;",
                 cal_items + sample_items, cal_items, sample_items);
        $display("%0d register writes. Checked %0d results with %0d calibration-done pulse(s); %0d errors.",
                 cfg_writes, results_checked, done_pulses, error_count);
        if (error_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ilm_pkg.sv
rtl/ilm_serial_arith.sv
rtl/idle_load_monitor_core.sv
test/idle_load_checker.sv
test/testbench.sv
